@@ rtl/core/adsc_pkg.sv @@
// ----------------------------------------------------------------------------
// adsc_pkg
// shared widths, register indexes and constants of the deadzone shaper
// ----------------------------------------------------------------------------
package adsc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PCT_W    = 7;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] DZ_RST   = 7'd0;
  localparam logic [PCT_W-1:0] SAT_RST  = 7'd100;

  // floor(x / 100) == (x * RECIP_M) >> RECIP_SH, exact for x below 2**22
  localparam int              RECIP_W  = 23;
  localparam int              RECIP_SH = 29;
  localparam logic [RECIP_W-1:0] RECIP_M = 23'd5368710;

  typedef enum logic [0:0] {
    CFG_DEADZONE   = 1'b0,
    CFG_SATURATION = 1'b1
  } cfg_idx_e;

endpackage

@@ rtl/core/adsc_in_if.sv @@
// ----------------------------------------------------------------------------
// adsc_in_if
// sample channel: selector and raw sample with valid/ready
// ----------------------------------------------------------------------------
interface adsc_in_if;

  logic                                   valid;
  logic                                   ready;
  logic                                   func;
  logic signed [adsc_pkg::SAMPLE_W-1:0]   sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink   (input valid, input func, input sample, output ready);

endinterface

@@ rtl/core/adsc_out_if.sv @@
// ----------------------------------------------------------------------------
// adsc_out_if
// result channel: shaped value with valid/ready
// ----------------------------------------------------------------------------
interface adsc_out_if;

  logic                                   valid;
  logic                                   ready;
  logic signed [adsc_pkg::SAMPLE_W-1:0]   shaped;

  modport source (output valid, output shaped, input ready);
  modport sink   (input valid, input shaped, output ready);

endinterface

@@ rtl/core/axis_deadzone_saturation_scale.sv @@
// ----------------------------------------------------------------------------
// axis_deadzone_saturation_scale
// deadzone and saturation shaping of stick axis and trigger samples
// ----------------------------------------------------------------------------
//  port        dir   handshake        payload
//  in_i        sink  valid/ready      func, sample
//  out_o       src   valid/ready      shaped
//  cfg_*_i     in    write enable     cfg_idx_i, cfg_data_i
//
//  one beat per cycle sustained while out_o is ready; the divider resolves
//  one quotient bit per stage
//  reset clears all valid bits and sets deadzone 0, saturation 100
//  a skid register behind the output register takes the beat in flight when
//  the sink stalls; in_i.ready drops only while the skid register is full
// ----------------------------------------------------------------------------
module axis_deadzone_saturation_scale #(
  parameter int AXIS_MAX    = 32767,
  parameter int TRIGGER_MAX = 255
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  adsc_in_if.sink                       in_i,
  adsc_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  adsc_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [adsc_pkg::PCT_W-1:0]    cfg_data_i
);

  import adsc_pkg::*;

  localparam int MAXR = (AXIS_MAX > TRIGGER_MAX) ? AXIS_MAX : TRIGGER_MAX;
  localparam int RW   = $clog2(MAXR + 1);
  localparam int PW   = RW + PCT_W;
  localparam int CW   = (RW + 1 > SAMPLE_W) ? RW + 1 : SAMPLE_W;
  localparam int NW   = RW + CW;
  localparam int MW   = RECIP_SH + CW;

  localparam logic [RW-1:0]       AXIS_R  = RW'(AXIS_MAX);
  localparam logic [RW-1:0]       TRIG_R  = RW'(TRIGGER_MAX);
  localparam logic [SAMPLE_W-1:0] AXIS_HI = SAMPLE_W'(AXIS_MAX);
  localparam logic [SAMPLE_W-1:0] AXIS_LO = ~AXIS_HI;
  localparam logic [SAMPLE_W-1:0] TRIG_HI = SAMPLE_W'(TRIGGER_MAX);

  typedef struct packed {
    logic                trig;
    logic                bypass;
    logic                neg;
    logic                zero;
    logic                sat;
    logic [SAMPLE_W-1:0] sample;
  } side_t;

  // configuration
  logic [PCT_W-1:0] dz_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q  <= DZ_RST;
      sat_q <= SAT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEADZONE:   dz_q  <= cfg_data_i;
        CFG_SATURATION: sat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic sk_v_q;
  assign en         = !sk_v_q;
  assign in_i.ready = en;

  // stage 1: range select, magnitude, range * percent
  logic [SAMPLE_W-1:0] smp, smp_abs, mag0;
  logic [RW-1:0]       rng0;
  side_t               side0;

  always_comb begin
    smp     = in_i.sample;
    smp_abs = smp[SAMPLE_W-1] ? (~smp + SAMPLE_W'(1)) : smp;
    rng0    = in_i.func ? TRIG_R : AXIS_R;
    // a negative trigger sample always lands inside the deadzone (bypass still passes it)
    if (in_i.func) begin
      mag0 = smp[SAMPLE_W-1] ? '0 : smp;
    end else begin
      mag0 = smp_abs;
    end
    side0.trig   = in_i.func;
    side0.bypass = (dz_q == '0) && (sat_q == PCT_FULL);
    side0.neg    = !in_i.func && smp[SAMPLE_W-1];
    side0.zero   = 1'b0;
    side0.sat    = 1'b0;
    side0.sample = smp;
  end

  logic          s1_v_q;
  side_t         s1_side_q;
  logic [CW-1:0] s1_mag_q;
  logic [RW-1:0] s1_rng_q;
  logic [PW-1:0] s1_pdz_q, s1_psat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q <= side0;
      s1_mag_q  <= CW'(mag0);
      s1_rng_q  <= rng0;
      s1_pdz_q  <= PW'(rng0) * PW'(dz_q);
      s1_psat_q <= PW'(rng0) * PW'(sat_q);
    end
  end

  // stage 2: cutoffs, divide by 100 through the reciprocal
  logic [MW-1:0] pm_dz, pm_sat;

  always_comb begin
    pm_dz  = MW'(s1_pdz_q) * MW'(RECIP_M);
    pm_sat = MW'(s1_psat_q) * MW'(RECIP_M);
  end

  logic          s2_v_q;
  side_t         s2_side_q;
  logic [CW-1:0] s2_mag_q, s2_dzc_q, s2_satc_q;
  logic [RW-1:0] s2_rng_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= s1_side_q;
      s2_mag_q  <= s1_mag_q;
      s2_rng_q  <= s1_rng_q;
      s2_dzc_q  <= pm_dz[RECIP_SH +: CW];
      s2_satc_q <= pm_sat[RECIP_SH +: CW];
    end
  end

  // stage 3: region compares, distance and span
  side_t side2;

  always_comb begin
    side2      = s2_side_q;
    side2.zero = (s2_mag_q <= s2_dzc_q);
    side2.sat  = (s2_mag_q >= s2_satc_q);
  end

  logic          s3_v_q;
  side_t         s3_side_q;
  logic [CW-1:0] s3_diff_q, s3_den_q;
  logic [RW-1:0] s3_rng_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_side_q <= side2;
      s3_rng_q  <= s2_rng_q;
      s3_diff_q <= s2_mag_q - s2_dzc_q;
      s3_den_q  <= s2_satc_q - s2_dzc_q;
    end
  end

  // divider: entry 0 holds range * distance, each later entry one quotient bit
  logic          dv_v_q  [0:RW];
  side_t         dv_sd_q [0:RW];
  logic [NW-1:0] dv_r_q  [0:RW];
  logic [RW-1:0] dv_q_q  [0:RW];
  logic [CW-1:0] dv_d_q  [0:RW];

  logic [NW-1:0] dv_r_d  [1:RW];
  logic [RW-1:0] dv_q_d  [1:RW];

  always_comb begin
    logic [NW-1:0] dsub;
    for (int j = 1; j <= RW; j++) begin
      dsub = NW'(dv_d_q[j-1]) << (RW - j);
      if (dv_r_q[j-1] >= dsub) begin
        dv_r_d[j] = dv_r_q[j-1] - dsub;
        dv_q_d[j] = dv_q_q[j-1] | (RW'(1) << (RW - j));
      end else begin
        dv_r_d[j] = dv_r_q[j-1];
        dv_q_d[j] = dv_q_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= RW; j++) begin
        dv_v_q[j] <= 1'b0;
      end
    end else if (en) begin
      dv_v_q[0] <= s3_v_q;
      for (int j = 1; j <= RW; j++) begin
        dv_v_q[j] <= dv_v_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_sd_q[0] <= s3_side_q;
      dv_r_q[0]  <= NW'(s3_rng_q) * NW'(s3_diff_q);
      dv_q_q[0]  <= '0;
      dv_d_q[0]  <= s3_den_q;
      for (int j = 1; j <= RW; j++) begin
        dv_sd_q[j] <= dv_sd_q[j-1];
        dv_r_q[j]  <= dv_r_d[j];
        dv_q_q[j]  <= dv_q_d[j];
        dv_d_q[j]  <= dv_d_q[j-1];
      end
    end
  end

  // result select
  side_t               fin;
  logic [SAMPLE_W-1:0] quo, res;

  always_comb begin
    fin = dv_sd_q[RW];
    quo = SAMPLE_W'(dv_q_q[RW]);
    if (fin.bypass) begin
      res = fin.sample;
    end else if (fin.zero) begin
      res = '0;
    end else if (fin.sat) begin
      res = fin.trig ? TRIG_HI : (fin.neg ? AXIS_LO : AXIS_HI);
    end else begin
      res = fin.neg ? (~quo + SAMPLE_W'(1)) : quo;
    end
  end

  // output register and skid register
  logic                o_v_q;
  logic [SAMPLE_W-1:0] o_d_q, sk_d_q;
  logic                beat_out;
  logic                last_v;

  assign beat_out     = o_v_q && out_o.ready;
  assign last_v       = dv_v_q[RW];
  assign out_o.valid  = o_v_q;
  assign out_o.shaped = o_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q  <= 1'b0;
      sk_v_q <= 1'b0;
    end else if (sk_v_q) begin
      if (beat_out) begin
        sk_v_q <= 1'b0;
      end
    end else if (!o_v_q || beat_out) begin
      o_v_q <= last_v;
    end else if (last_v) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (beat_out) begin
        o_d_q <= sk_d_q;
      end
    end else if (!o_v_q || beat_out) begin
      o_d_q <= res;
    end else if (last_v) begin
      sk_d_q <= res;
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> o_v_q)
    else $error("skid register full while output register empty");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q && !out_o.ready |=> sk_v_q && $stable(sk_d_q))
    else $error("skid register changed while sink stalled");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |=> $stable(last_v) && $stable(s1_v_q) && $stable(s3_v_q))
    else $error("pipeline moved while stalled");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_v && !fin.bypass && !fin.zero && !fin.sat |->
      dv_q_q[RW] < (fin.trig ? TRIG_R : AXIS_R))
    else $error("rescaled quotient reached the range");

endmodule
